// ===== rtl/stf_pkg.sv =====
// shared types and constants for the subarray target-sum finder
package stf_pkg;

    localparam int MAX_LEN_DEF  = 8;
    localparam int ELEM_W_DEF   = 16;
    localparam int TARGET_W     = 19;
    localparam int INDEX_OUT_W  = 3;
    localparam int MATCH_CNT_W  = 6;
    localparam int M_DATA_W     = 16;

    localparam logic KIND_MATCH = 1'b0;
    localparam logic KIND_DONE  = 1'b1;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SEARCH,
        ST_DONE
    } stf_state_t;

    // control from the sequencer to the accumulate unit
    typedef struct packed {
        logic step;     // take the current element into the running sum
        logic restart;  // current element opens a new run
    } sum_ctl_t;

endpackage

// ===== rtl/stf_sum_unit.sv =====
// shared accumulate and compare unit: running run sum against the target
module stf_sum_unit #(
    parameter int MAX_LEN       = stf_pkg::MAX_LEN_DEF,
    parameter int ELEMENT_WIDTH = stf_pkg::ELEM_W_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  stf_pkg::sum_ctl_t                   ctl,
    input  logic signed [ELEMENT_WIDTH-1:0]     elem,
    input  logic signed [stf_pkg::TARGET_W-1:0] target,
    output logic                                match
);

    localparam int SUM_W = ELEMENT_WIDTH + $clog2(MAX_LEN + 1);
    localparam int CMP_W = (SUM_W > stf_pkg::TARGET_W) ? SUM_W : stf_pkg::TARGET_W;

    logic signed [SUM_W-1:0] sum_reg;
    logic signed [SUM_W-1:0] sum_next;
    logic signed [SUM_W-1:0] base;
    logic signed [CMP_W-1:0] sum_cmp;
    logic signed [CMP_W-1:0] target_cmp;

    always_comb begin
        base       = ctl.restart ? '0 : sum_reg;
        sum_next   = base + SUM_W'(elem);
        sum_cmp    = CMP_W'(sum_next);
        target_cmp = CMP_W'(target);
        match      = (sum_cmp == target_cmp);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= '0;
        end else if (ctl.step) begin
            sum_reg <= sum_next;
        end
    end

endmodule

// ===== rtl/subarray_target_sum_finder.sv =====
// top level of the subarray target-sum finder
//
// Elements arrive one per input beat on s_tdata and are kept in a small
// register store of MAX_LEN entries; once the store is full, further
// elements are dropped and the done beat reports it. The beat with s_tlast
// set is stored like any other and then starts the search: every run
// [start..end] is visited in order of start and then of end, one element
// added and compared against target_sum per cycle, unless a match waits
// for a full output register, in a single shared accumulate-and-compare
// unit. Each run whose exact sum equals the target goes out as a match
// beat (m_tuser low); one done beat with m_tuser and m_tlast high follows,
// carrying the match count and the overflow flag, and the store is then
// emptied. s_tready is high while loading. The search holds s_tready low
// through its n*(n+1)/2 runs, n the number of stored elements (36 at
// MAX_LEN = 8), through the done beat, and through any m_tready stall of
// a pending beat. The output register lets the search run on while a beat
// waits, until the next match needs it. target_sum is written through
// cfg_we/cfg_wdata and should only change while no array is being searched.
module subarray_target_sum_finder #(
    parameter int MAX_LEN       = stf_pkg::MAX_LEN_DEF,
    parameter int ELEMENT_WIDTH = stf_pkg::ELEM_W_DEF
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    // configuration: target_sum
    input  logic                                      cfg_we,
    input  logic [stf_pkg::TARGET_W-1:0]              cfg_wdata,
    // element beats
    input  logic                                      s_tvalid,
    output logic                                      s_tready,
    input  logic [((ELEMENT_WIDTH+7)/8)*8-1:0]        s_tdata,  // element_value
    input  logic                                      s_tlast,  // final_element
    // result beats
    output logic                                      m_tvalid,
    input  logic                                      m_tready,
    // start_index, end_index, match_count, overflow_flag, zero pad
    output logic [stf_pkg::M_DATA_W-1:0]              m_tdata,
    output logic                                      m_tuser,  // result_kind
    output logic                                      m_tlast   // run_last
);

    localparam int IDX_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CNT_W = $clog2(MAX_LEN + 1);

    // element store, written at the fill count, read at the run end index
    logic [ELEMENT_WIDTH-1:0] store_reg [MAX_LEN];
    logic                     store_we;

    stf_pkg::stf_state_t state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                dropped_reg, dropped_next;
    logic [stf_pkg::TARGET_W-1:0] target_reg;

    // run pointers and match tally
    logic [IDX_W-1:0]    start_reg, start_next;
    logic [IDX_W-1:0]    end_reg, end_next;
    logic [stf_pkg::MATCH_CNT_W-1:0] matches_reg, matches_next;

    // output register
    logic                                m_valid_reg, m_valid_next;
    logic                                kind_reg, kind_next;
    logic [stf_pkg::INDEX_OUT_W-1:0]     o_start_reg, o_start_next;
    logic [stf_pkg::INDEX_OUT_W-1:0]     o_end_reg, o_end_next;
    logic [stf_pkg::MATCH_CNT_W-1:0]     o_count_reg, o_count_next;
    logic                                o_ovf_reg, o_ovf_next;
    logic                                o_last_reg, o_last_next;

    stf_pkg::sum_ctl_t sum_ctl;
    logic              sum_match;
    logic              out_free;
    logic              in_beat;
    logic              end_is_last;
    logic              start_is_last;

    stf_sum_unit #(
        .MAX_LEN       (MAX_LEN),
        .ELEMENT_WIDTH (ELEMENT_WIDTH)
    ) u_sum (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (sum_ctl),
        .elem    (store_reg[end_reg]),
        .target  (target_reg),
        .match   (sum_match)
    );

    assign s_tready = (state_reg == stf_pkg::ST_LOAD);
    assign in_beat  = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    // last valid index is count - 1
    assign end_is_last   = ((CNT_W'(end_reg) + CNT_W'(1)) == count_reg);
    assign start_is_last = ((CNT_W'(start_reg) + CNT_W'(1)) == count_reg);

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        dropped_next = dropped_reg;
        start_next   = start_reg;
        end_next     = end_reg;
        matches_next = matches_reg;
        store_we     = 1'b0;
        sum_ctl      = '0;

        m_valid_next = m_valid_reg && !m_tready;
        kind_next    = kind_reg;
        o_start_next = o_start_reg;
        o_end_next   = o_end_reg;
        o_count_next = o_count_reg;
        o_ovf_next   = o_ovf_reg;
        o_last_next  = o_last_reg;

        unique case (state_reg)
            stf_pkg::ST_LOAD: begin
                if (in_beat) begin
                    if (count_reg < CNT_W'(MAX_LEN)) begin
                        store_we   = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end else begin
                        dropped_next = 1'b1;
                    end
                    if (s_tlast) begin
                        start_next = '0;
                        end_next   = '0;
                        state_next = stf_pkg::ST_SEARCH;
                    end
                end
            end

            stf_pkg::ST_SEARCH: begin
                // a match waits here only while the output register is full
                sum_ctl.restart = (end_reg == start_reg);
                sum_ctl.step    = !sum_match || out_free;
                if (sum_match && out_free) begin
                    m_valid_next = 1'b1;
                    kind_next    = stf_pkg::KIND_MATCH;
                    o_start_next = stf_pkg::INDEX_OUT_W'(start_reg);
                    o_end_next   = stf_pkg::INDEX_OUT_W'(end_reg);
                    o_count_next = '0;
                    o_ovf_next   = 1'b0;
                    o_last_next  = 1'b0;
                    matches_next = matches_reg + stf_pkg::MATCH_CNT_W'(1);
                end
                if (sum_ctl.step) begin
                    if (!end_is_last) begin
                        end_next = end_reg + IDX_W'(1);
                    end else if (!start_is_last) begin
                        start_next = start_reg + IDX_W'(1);
                        end_next   = start_reg + IDX_W'(1);
                    end else begin
                        state_next = stf_pkg::ST_DONE;
                    end
                end
            end

            stf_pkg::ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    kind_next    = stf_pkg::KIND_DONE;
                    o_start_next = '0;
                    o_end_next   = '0;
                    o_count_next = matches_reg;
                    o_ovf_next   = dropped_reg;
                    o_last_next  = 1'b1;
                    count_next   = '0;
                    dropped_next = 1'b0;
                    matches_next = '0;
                    state_next   = stf_pkg::ST_LOAD;
                end
            end

            default: begin
                state_next = stf_pkg::ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= stf_pkg::ST_LOAD;
            count_reg   <= '0;
            dropped_reg <= 1'b0;
            target_reg  <= '0;
            start_reg   <= '0;
            end_reg     <= '0;
            matches_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            dropped_reg <= dropped_next;
            start_reg   <= start_next;
            end_reg     <= end_next;
            matches_reg <= matches_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                target_reg <= cfg_wdata;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        kind_reg    <= kind_next;
        o_start_reg <= o_start_next;
        o_end_reg   <= o_end_next;
        o_count_reg <= o_count_next;
        o_ovf_reg   <= o_ovf_next;
        o_last_reg  <= o_last_next;
        if (store_we) begin
            store_reg[count_reg[IDX_W-1:0]] <= s_tdata[ELEMENT_WIDTH-1:0];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = kind_reg;
    assign m_tlast  = o_last_reg;
    assign m_tdata  = stf_pkg::M_DATA_W'({o_ovf_reg, o_count_reg, o_end_reg, o_start_reg});

endmodule

// ===== test/tb.sv =====
// self-checking testbench for the subarray target-sum finder
module tb;

    localparam int MAX_LEN     = stf_pkg::MAX_LEN_DEF;
    localparam int ELEM_W      = stf_pkg::ELEM_W_DEF;
    localparam int TARGET_W    = stf_pkg::TARGET_W;
    localparam int INDEX_OUT_W = stf_pkg::INDEX_OUT_W;
    localparam int MATCH_CNT_W = stf_pkg::MATCH_CNT_W;
    localparam int M_DATA_W    = stf_pkg::M_DATA_W;
    localparam int RX_HOLD  = 250;      // long receiver hold-off, in cycles
    localparam int SETTLE   = 60;       // cycles of margin after the last beat

    // one result beat, split into its fields
    typedef struct {
        logic                   kind;
        logic [INDEX_OUT_W-1:0] first_idx;
        logic [INDEX_OUT_W-1:0] last_idx;
        logic [MATCH_CNT_W-1:0] hits;
        logic                   ovf;
        logic                   done;
    } finder_result_t;

    // keeps its own copy of the element store and target, and the queue
    // of result beats still owed by the block
    class subarray_scoreboard;
        logic signed [ELEM_W-1:0]   held_elems[MAX_LEN];
        int unsigned                held_n;
        bit                         dropped;
        logic signed [TARGET_W-1:0] target;
        finder_result_t             owed_results[$];
        int                         errors;
        int                         match_beats;
        int                         done_beats;
        int                         overflow_runs;

        function new();
            held_n        = 0;
            dropped       = 0;
            target        = '0;
            errors        = 0;
            match_beats   = 0;
            done_beats    = 0;
            overflow_runs = 0;
        endfunction

        function void set_target(logic signed [TARGET_W-1:0] t);
            target = t;
        endfunction

        // accepted element beat: store it, and on the final one walk all runs
        function void note_element(logic signed [ELEM_W-1:0] v, bit final_beat);
            int             run_sum;
            int             found;
            finder_result_t r;
            if (held_n < MAX_LEN) begin
                held_elems[held_n] = v;
                held_n++;
            end else begin
                dropped = 1;
            end
            if (!final_beat)
                return;
            found = 0;
            for (int i = 0; i < held_n; i++) begin
                run_sum = 0;
                for (int j = i; j < held_n; j++) begin
                    run_sum += held_elems[j];
                    if (run_sum == int'(target)) begin
                        r.kind      = stf_pkg::KIND_MATCH;
                        r.first_idx = i[INDEX_OUT_W-1:0];
                        r.last_idx  = j[INDEX_OUT_W-1:0];
                        r.hits      = '0;
                        r.ovf       = 1'b0;
                        r.done      = 1'b0;
                        owed_results.push_back(r);
                        found++;
                    end
                end
            end
            r.kind      = stf_pkg::KIND_DONE;
            r.first_idx = '0;
            r.last_idx  = '0;
            r.hits      = found[MATCH_CNT_W-1:0];
            r.ovf       = dropped;
            r.done      = 1'b1;
            owed_results.push_back(r);
            if (dropped)
                overflow_runs++;
            held_n  = 0;
            dropped = 0;
        endfunction

        function void check_result(logic [M_DATA_W-1:0] data, logic user, logic last);
            finder_result_t e;
            finder_result_t a;
            a.kind      = user;
            a.first_idx = data[INDEX_OUT_W-1:0];
            a.last_idx  = data[2*INDEX_OUT_W-1:INDEX_OUT_W];
            a.hits      = data[2*INDEX_OUT_W+MATCH_CNT_W-1:2*INDEX_OUT_W];
            a.ovf       = data[2*INDEX_OUT_W+MATCH_CNT_W];
            a.done      = last;
            if (owed_results.size() == 0) begin
                $error("unexpected result beat: kind %0d start %0d end %0d count %0d",
                       a.kind, a.first_idx, a.last_idx, a.hits);
                errors++;
                return;
            end
            e = owed_results.pop_front();
            if (a.kind == stf_pkg::KIND_DONE)
                done_beats++;
            else
                match_beats++;
            if (a.kind !== e.kind) begin
                $error("result_kind: expected %0d, got %0d", e.kind, a.kind);
                errors++;
            end
            if (a.first_idx !== e.first_idx) begin
                $error("start_index: expected %0d, got %0d", e.first_idx, a.first_idx);
                errors++;
            end
            if (a.last_idx !== e.last_idx) begin
                $error("end_index: expected %0d, got %0d", e.last_idx, a.last_idx);
                errors++;
            end
            if (a.hits !== e.hits) begin
                $error("match_count: expected %0d, got %0d", e.hits, a.hits);
                errors++;
            end
            if (a.ovf !== e.ovf) begin
                $error("overflow_flag: expected %0d, got %0d", e.ovf, a.ovf);
                errors++;
            end
            if (a.done !== e.done) begin
                $error("run_last: expected %0d, got %0d", e.done, a.done);
                errors++;
            end
        endfunction

        function int pending();
            return owed_results.size();
        endfunction
    endclass

    // clock, reset and block inputs, all known from time zero
    logic                        aclk     = 1'b0;
    logic                        aresetn  = 1'b0;
    logic                        cfg_we   = 1'b0;
    logic [TARGET_W-1:0]         cfg_wdata = '0;
    logic                        s_tvalid = 1'b0;
    logic                        s_tready;
    logic [((ELEM_W+7)/8)*8-1:0] s_tdata  = '0;    // element_value
    logic                        s_tlast  = 1'b0;  // final_element
    logic                        m_tvalid;
    logic                        m_tready = 1'b0;
    // start_index, end_index, match_count, overflow_flag, zero pad
    logic [M_DATA_W-1:0]         m_tdata;
    logic                        m_tuser;          // result_kind
    logic                        m_tlast;          // run_last

    subarray_scoreboard sb;
    int   tx_idle_pct = 0;
    int   rx_idle_pct = 0;
    int   items_sent  = 0;
    int   arrays_sent = 0;
    logic rx_holding  = 1'b0;
    event hold_go;

    subarray_target_sum_finder dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always #1 aclk = ~aclk;

    // receiver: random back-pressure, or a long hold-off when asked
    always @(posedge aclk) begin
        if (rx_holding)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // hold-off length is counted here, independent of the sender
    initial begin
        forever begin
            @(hold_go);
            rx_holding <= 1'b1;
            repeat (RX_HOLD) @(posedge aclk);
            rx_holding <= 1'b0;
        end
    end

    // every accepted result beat is checked against the oldest owed one
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser, m_tlast);
    end

    // one element beat, with random idle cycles in front of it
    task automatic send_element(logic [ELEM_W-1:0] v, bit final_beat);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        s_tlast  <= final_beat;
        do
            @(posedge aclk);
        while (!s_tready);
        sb.note_element(v, final_beat);
        items_sent++;
        if (final_beat)
            arrays_sent++;
    endtask

    // target written only while the block is quiet
    task automatic write_target(logic [TARGET_W-1:0] t);
        cfg_we    <= 1'b1;
        cfg_wdata <= t;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        sb.set_target(t);
    endtask

    // stop offering beats until every owed result is in, then let it settle
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    function automatic logic [TARGET_W-1:0] pick_target();
        int t;
        case ($urandom_range(6))
            0, 1, 2: t = int'($urandom_range(12)) - 6;
            3:       t = int'($urandom_range(65534)) - 32767;
            4:       t = ($urandom_range(1) != 0) ? -262144 : 262143;
            default: t = int'($urandom);
        endcase
        return t[TARGET_W-1:0];
    endfunction

    function automatic logic [ELEM_W-1:0] pick_element(int flavor);
        int v;
        case (flavor)
            0: v = int'($urandom_range(6)) - 3;
            1: v = int'($urandom);
            2: begin
                case ($urandom_range(2))
                    0:       v = -32768;
                    1:       v = 32767;
                    default: v = 0;
                endcase
            end
            default: v = int'($urandom_range(200)) - 100;
        endcase
        return v[ELEM_W-1:0];
    endfunction

    // random-length array, now and then longer than the store holds
    task automatic send_random_array();
        int len;
        int flavor;
        if ($urandom_range(7) == 0)
            len = $urandom_range(MAX_LEN + 4, MAX_LEN + 1);
        else
            len = $urandom_range(MAX_LEN, 1);
        flavor = $urandom_range(3);
        for (int k = 0; k < len; k++)
            send_element(pick_element(flavor), k == len - 1);
    endtask

    initial begin
        int quota;
        sb = new();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: all-zero full array under the reset target, every run matches
        for (int k = 0; k < MAX_LEN; k++)
            send_element('0, k == MAX_LEN - 1);
        // single-element array that is its own match
        send_element('0, 1'b1);
        drain_results();

        // most negative target, reached only by the full array of minimum
        // elements; one more element overflows the store and is dropped
        write_target(TARGET_W'(-262144));
        for (int k = 0; k <= MAX_LEN; k++)
            send_element(16'h8000, k == MAX_LEN);
        drain_results();

        // most positive target, out of reach
        write_target(TARGET_W'(262143));
        send_element(16'h7fff, 1'b0);
        send_element(16'h7fff, 1'b1);
        drain_results();

        // sum beyond the element width must not wrap and lose the true match of run 0..1
        write_target(TARGET_W'(65534));
        send_element(16'h7fff, 1'b0);
        send_element(16'h7fff, 1'b0);
        send_element(16'hffff, 1'b1);
        drain_results();

        // random arrays under three back-pressure profiles, new target per phase
        for (int mode = 0; mode < 3; mode++) begin
            case (mode)
                0: begin
                    tx_idle_pct = 19;
                    rx_idle_pct = 87;
                end
                1: begin
                    tx_idle_pct = 87;
                    rx_idle_pct = 19;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            for (int phase = 0; phase < 4; phase++) begin
                drain_results();
                write_target(pick_target());
                // receiver stalls long while the sender keeps pushing arrays,
                // so the result register and then the input side back up
                if (mode == 2 && phase == 1)
                    -> hold_go;
                quota = items_sent + 26;
                while (items_sent < quota)
                    send_random_array();
            end
        end

        drain_results();
        $display("searched %0d arrays from %0d element beats, %0d of them overflowed",
                 arrays_sent, items_sent, sb.overflow_runs);
        $display("checked %0d match beats and %0d done beats", sb.match_beats,
                 sb.done_beats);
        if (sb.errors == 0)
            $display("subarray_target_sum_finder verification clean");
        else
            $display("subarray_target_sum_finder verification failed");
        $finish;
    end

    // watchdog
    initial begin
        #2000000;
        $display("subarray_target_sum_finder verification failed");
        $finish;
    end

endmodule
